// ===== rtl/rssf_pkg.sv =====
package rssf_pkg;

  localparam int unsigned IDX_W     = 9;
  localparam int unsigned RANGE_W   = 10;
  localparam int unsigned ANG_W     = 9;
  localparam int unsigned QUAD_W    = 2;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned THR_W     = 10;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned TRIG_W    = 16;
  localparam int unsigned PROD_W    = 27;
  localparam int unsigned FRAC_W    = 15;
  localparam int unsigned FRAC_IDX_W = 7;
  localparam int unsigned TRIG_ROM_N = 128;

  localparam int unsigned SCAN_ANGLES_DEF = 128;
  localparam int unsigned MID_DEPTH_DEF   = 4;
  localparam int unsigned OUT_DEPTH_DEF   = 8;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [THR_W-1:0]   DELTA_THRESHOLD_RST = 10'd5;
  localparam logic [LEN_W-1:0]   MIN_LENGTH_RST      = 9'd5;
  localparam logic [RANGE_W-1:0] MIN_RANGE_RST       = 10'd0;

  // angle offset and fixed x,y offset of each sensor quadrant
  localparam logic [ANG_W:0] QUAD_ANGLE [4] = '{10'd0, 10'd90, 10'd180, 10'd270};
  localparam logic signed [POS_W-1:0] QUAD_X_OFF [4] = '{12'sd0, 12'sd90, 12'sd90, 12'sd0};
  localparam logic signed [POS_W-1:0] QUAD_Y_OFF [4] = '{12'sd0, 12'sd0, 12'sd90, 12'sd90};

  localparam longint COS1_Q30 = 64'sd1073578288;
  localparam longint SIN1_Q30 = 64'sd18739379;

  typedef enum logic [1:0] {
    REG_DELTA_THRESHOLD = 2'd0,
    REG_MIN_LENGTH      = 2'd1,
    REG_MIN_RANGE       = 2'd2
  } reg_e;

  typedef struct packed {
    logic [THR_W-1:0]   delta_threshold;
    logic [LEN_W-1:0]   min_length;
    logic [RANGE_W-1:0] min_range;
  } cfg_t;

  // closed run that passed the length and range checks
  typedef struct packed {
    logic [ANG_W-1:0]   ang_base;
    logic [RANGE_W-1:0] mid_range;
    logic [QUAD_W-1:0]  quadrant;
  } seg_t;

  typedef struct packed {
    logic [ANG_W-1:0]         mid_angle;
    logic [RANGE_W-1:0]       mid_range;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [QUAD_W-1:0]        source_quadrant;
  } res_t;

  // Q1.15 sine of 0..90 degrees by repeated one-degree rotation in Q2.30;
  // evaluated at elaboration only
  function automatic logic [TRIG_W-1:0] sin_q15(input int unsigned d);
    longint x;
    longint y;
    longint nx;
    longint ny;
    longint v;
    int unsigned n;
    int unsigned i;
    n = (d > 90) ? 90 : d;
    x = longint'(1) <<< 30;
    y = 0;
    for (i = 0; i < n; i++) begin
      nx = (x * COS1_Q30 - y * SIN1_Q30 + (longint'(1) <<< 29)) >>> 30;
      ny = (y * COS1_Q30 + x * SIN1_Q30 + (longint'(1) <<< 29)) >>> 30;
      x = nx;
      y = ny;
    end
    v = (y + (longint'(1) <<< 14)) >>> 15;
    if (v > 32767) v = 32767;
    if (v < 0) v = 0;
    return v[TRIG_W-1:0];
  endfunction

endpackage

// ===== rtl/range_scan_segment_finder.sv =====
// Channel   Handshake              Ports
// input     push / full            range_sample_i, quadrant_i, last_sample_i
// result    pop / empty            mid_angle_o, mid_range_o, pos_x_o, pos_y_o,
//                                  source_quadrant_o
// config    APB psel/penable       paddr 0x0 delta_threshold, 0x4 min_length,
//                                  0x8 min_range
//
// One sample is taken every cycle while full is low; run tracking completes in the cycle of the transfer.
// A closed run passes through the segment queue, then four stages of angle, table and
// multiplier, then the result queue, before it shows on the result ports.
// full rises only when the segment queue is full; the back end stalls on the result
// queue by credit, so a held pop backs up into full.
// Reset clears the run state and both queues and loads the register defaults.
module range_scan_segment_finder #(
  parameter int unsigned SCAN_ANGLES = rssf_pkg::SCAN_ANGLES_DEF,
  parameter int unsigned MID_DEPTH   = rssf_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH   = rssf_pkg::OUT_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               push,
  output logic                               full,
  input  logic [rssf_pkg::RANGE_W-1:0]       range_sample_i,
  input  logic [rssf_pkg::QUAD_W-1:0]        quadrant_i,
  input  logic                               last_sample_i,

  output logic                               empty,
  input  logic                               pop,
  output logic [rssf_pkg::ANG_W-1:0]         mid_angle_o,
  output logic [rssf_pkg::RANGE_W-1:0]       mid_range_o,
  output logic signed [rssf_pkg::POS_W-1:0]  pos_x_o,
  output logic signed [rssf_pkg::POS_W-1:0]  pos_y_o,
  output logic [rssf_pkg::QUAD_W-1:0]        source_quadrant_o,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rssf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rssf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rssf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int unsigned DATA_W = rssf_pkg::APB_DATA_W;

  rssf_pkg::cfg_t cfg_q, cfg_d;
  rssf_pkg::reg_e reg_sel;
  logic           cfg_wr;
  logic           accept;
  logic           seg_push;
  rssf_pkg::seg_t seg_in;
  rssf_pkg::seg_t seg_out;
  logic           seg_empty;
  logic           seg_pop;
  rssf_pkg::res_t res;
  logic [$clog2(MID_DEPTH+1)-1:0] seg_count;

  assign pready  = 1'b1;
  assign reg_sel = rssf_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        rssf_pkg::REG_DELTA_THRESHOLD:
          cfg_d.delta_threshold = pwdata[rssf_pkg::THR_W-1:0];
        rssf_pkg::REG_MIN_LENGTH:
          cfg_d.min_length = pwdata[rssf_pkg::LEN_W-1:0];
        rssf_pkg::REG_MIN_RANGE:
          cfg_d.min_range = pwdata[rssf_pkg::RANGE_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      rssf_pkg::REG_DELTA_THRESHOLD: prdata = DATA_W'(cfg_q.delta_threshold);
      rssf_pkg::REG_MIN_LENGTH:      prdata = DATA_W'(cfg_q.min_length);
      rssf_pkg::REG_MIN_RANGE:       prdata = DATA_W'(cfg_q.min_range);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delta_threshold <= rssf_pkg::DELTA_THRESHOLD_RST;
      cfg_q.min_length      <= rssf_pkg::MIN_LENGTH_RST;
      cfg_q.min_range       <= rssf_pkg::MIN_RANGE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign accept = push && !full;

  rssf_front #(
    .SCAN_ANGLES (SCAN_ANGLES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .range_sample_i (range_sample_i),
    .quadrant_i     (quadrant_i),
    .last_sample_i  (last_sample_i),
    .cfg_i          (cfg_q),
    .seg_push_o     (seg_push),
    .seg_o          (seg_in)
  );

  rssf_fifo #(
    .WIDTH ($bits(rssf_pkg::seg_t)),
    .DEPTH (MID_DEPTH)
  ) u_seg_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (seg_push),
    .wdata_i (seg_in),
    .pop_i   (seg_pop),
    .rdata_o (seg_out),
    .full_o  (full),
    .empty_o (seg_empty),
    .count_o (seg_count)
  );

  rssf_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_i       (seg_out),
    .seg_empty_i (seg_empty),
    .seg_pop_o   (seg_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign mid_angle_o       = res.mid_angle;
  assign mid_range_o       = res.mid_range;
  assign pos_x_o           = res.pos_x;
  assign pos_y_o           = res.pos_y;
  assign source_quadrant_o = res.source_quadrant;

  a_seg_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_count <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
    else $error("segment queue count out of range");

  a_seg_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_push |-> accept && !full)
    else $error("segment queued without an input transfer");

endmodule

// ===== rtl/rssf_fifo.sv =====
module rssf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = rssf_pkg::MID_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/rssf_front.sv =====
module rssf_front #(
  parameter int unsigned SCAN_ANGLES = rssf_pkg::SCAN_ANGLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [rssf_pkg::RANGE_W-1:0]    range_sample_i,
  input  logic [rssf_pkg::QUAD_W-1:0]     quadrant_i,
  input  logic                            last_sample_i,
  input  rssf_pkg::cfg_t                  cfg_i,
  output logic                            seg_push_o,
  output rssf_pkg::seg_t                  seg_o
);

  localparam int unsigned IDX_W   = rssf_pkg::IDX_W;
  localparam int unsigned RANGE_W = rssf_pkg::RANGE_W;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SCAN_ANGLES - 1);

  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   start_idx_q, start_idx_d;
  logic [RANGE_W-1:0] start_range_q, start_range_d;
  logic [RANGE_W-1:0] prev_range_q;

  logic               first;
  logic [RANGE_W-1:0] diff;
  logic               cont;
  logic               close_en;
  logic [IDX_W-1:0]   end_idx;
  logic [RANGE_W-1:0] end_range;
  logic [IDX_W:0]     span;
  logic               span_ok;
  logic [RANGE_W:0]   range_sum;
  logic [RANGE_W-1:0] mid_range;
  logic               range_ok;
  logic [IDX_W:0]     idx_sum;

  assign first     = (idx_q == '0);
  assign diff      = (range_sample_i > prev_range_q) ? range_sample_i - prev_range_q
                                                     : prev_range_q - range_sample_i;
  assign cont      = (diff < cfg_i.delta_threshold);
  assign close_en  = !first && (!cont || last_sample_i);
  assign end_idx   = cont ? idx_q : idx_q - 1'b1;
  assign end_range = cont ? range_sample_i : prev_range_q;

  // end below start after index saturation reads as a negative span
  assign span      = {1'b0, end_idx} - {1'b0, start_idx_q};
  assign span_ok   = $signed(span) > $signed({1'b0, cfg_i.min_length});
  assign range_sum = {1'b0, start_range_q} + {1'b0, end_range};
  assign mid_range = range_sum[RANGE_W:1];
  assign range_ok  = mid_range > cfg_i.min_range;
  assign idx_sum   = {1'b0, start_idx_q} + {1'b0, end_idx};

  assign seg_push_o         = accept_i && close_en && span_ok && range_ok;
  assign seg_o.ang_base     = idx_sum[IDX_W:1];
  assign seg_o.mid_range    = mid_range;
  assign seg_o.quadrant     = quadrant_i;

  always_comb begin
    start_idx_d   = start_idx_q;
    start_range_d = start_range_q;
    if (first) begin
      start_idx_d   = '0;
      start_range_d = range_sample_i;
    end else if (!cont) begin
      start_idx_d   = idx_q;
      start_range_d = range_sample_i;
    end
    if (last_sample_i) begin
      idx_d = '0;
    end else if (idx_q < IDX_MAX) begin
      idx_d = idx_q + 1'b1;
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q         <= '0;
      start_idx_q   <= '0;
      start_range_q <= '0;
      prev_range_q  <= '0;
    end else if (accept_i) begin
      idx_q         <= idx_d;
      start_idx_q   <= start_idx_d;
      start_range_q <= start_range_d;
      prev_range_q  <= range_sample_i;
    end
  end

  a_idx_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_MAX)
    else $error("sample index beyond scan length");

  a_last_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_sample_i |=> idx_q == '0)
    else $error("index not rewound after last sample");

endmodule

// ===== rtl/rssf_back.sv =====
module rssf_back #(
  parameter int unsigned OUT_DEPTH = rssf_pkg::OUT_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rssf_pkg::seg_t   seg_i,
  input  logic             seg_empty_i,
  output logic             seg_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output rssf_pkg::res_t   res_o
);

  localparam int unsigned ANG_W   = rssf_pkg::ANG_W;
  localparam int unsigned RANGE_W = rssf_pkg::RANGE_W;
  localparam int unsigned QUAD_W  = rssf_pkg::QUAD_W;
  localparam int unsigned POS_W   = rssf_pkg::POS_W;
  localparam int unsigned TRIG_W  = rssf_pkg::TRIG_W;
  localparam int unsigned PROD_W  = rssf_pkg::PROD_W;
  localparam int unsigned FRAC_W  = rssf_pkg::FRAC_W;
  localparam int unsigned F_W     = rssf_pkg::FRAC_IDX_W;
  localparam int unsigned ROM_N   = rssf_pkg::TRIG_ROM_N;
  localparam int unsigned CNT_W   = $clog2(OUT_DEPTH+1);
  localparam int unsigned STAGES  = 4;
  localparam int unsigned USED_W  = CNT_W + 1;

  // sine table, 0..90 degrees, larger indexes clamp at 90
  logic [TRIG_W-1:0] sin_rom [ROM_N];
  for (genvar g = 0; g < ROM_N; g++) begin : g_sin
    localparam logic [TRIG_W-1:0] SIN_VAL = rssf_pkg::sin_q15(g);
    assign sin_rom[g] = SIN_VAL;
  end

  logic [STAGES-1:0] vld_q, vld_d;

  // stage 1: angle with quadrant offset, wrapped
  logic [ANG_W-1:0]   ang1_q;
  logic [RANGE_W-1:0] mr1_q;
  logic [QUAD_W-1:0]  q1_q;
  logic [ANG_W:0]     ang_sum;
  logic [ANG_W-1:0]   ang_wrap;

  // stage 2: angle quadrant and angle within it
  logic [ANG_W-1:0]   ang2_q;
  logic [RANGE_W-1:0] mr2_q;
  logic [QUAD_W-1:0]  q2_q;
  logic [1:0]         aq2_q;
  logic [F_W-1:0]     f2_q;
  logic [1:0]         aq;
  logic [ANG_W-1:0]   ang_base;
  logic [ANG_W-1:0]   ang_rem;

  // stage 3: signed sine and cosine
  logic [ANG_W-1:0]          ang3_q;
  logic [RANGE_W-1:0]        mr3_q;
  logic [QUAD_W-1:0]         q3_q;
  logic signed [TRIG_W-1:0]  sn3_q, cs3_q;
  logic signed [TRIG_W-1:0]  sf, cf, sn, cs;

  // stage 4: products
  logic [ANG_W-1:0]          ang4_q;
  logic [RANGE_W-1:0]        mr4_q;
  logic [QUAD_W-1:0]         q4_q;
  logic signed [PROD_W-1:0]  px4_q, py4_q;
  logic signed [PROD_W-1:0]  rnd_x, rnd_y;

  rssf_pkg::res_t        res_d;
  logic                  out_full;
  logic [CNT_W-1:0]      out_count;
  logic [USED_W-1:0]     used;
  logic                  take;

  // credit check: every item in flight has a slot waiting in the output queue
  assign used = USED_W'(out_count) + USED_W'($countones(vld_q));
  assign take = !seg_empty_i && (used < USED_W'(OUT_DEPTH));
  assign seg_pop_o = take;
  assign vld_d = {vld_q[STAGES-2:0], take};

  assign ang_sum  = {1'b0, seg_i.ang_base} + rssf_pkg::QUAD_ANGLE[seg_i.quadrant];
  assign ang_wrap = (ang_sum >= (ANG_W+1)'(360)) ? ANG_W'(ang_sum - (ANG_W+1)'(360))
                                                  : ang_sum[ANG_W-1:0];

  always_comb begin
    if (ang1_q >= ANG_W'(270)) begin
      aq       = 2'd3;
      ang_base = ANG_W'(270);
    end else if (ang1_q >= ANG_W'(180)) begin
      aq       = 2'd2;
      ang_base = ANG_W'(180);
    end else if (ang1_q >= ANG_W'(90)) begin
      aq       = 2'd1;
      ang_base = ANG_W'(90);
    end else begin
      aq       = 2'd0;
      ang_base = '0;
    end
    ang_rem = ang1_q - ang_base;
  end

  assign sf = $signed(sin_rom[f2_q]);
  assign cf = $signed(sin_rom[F_W'(90) - f2_q]);

  always_comb begin
    case (aq2_q)
      2'd0: begin
        sn = sf;
        cs = cf;
      end
      2'd1: begin
        sn = cf;
        cs = -sf;
      end
      2'd2: begin
        sn = -sf;
        cs = -cf;
      end
      default: begin
        sn = -cf;
        cs = sf;
      end
    endcase
  end

  // round half up: floor((p + 2^14) / 2^15)
  assign rnd_x = px4_q + PROD_W'(1 << (FRAC_W-1));
  assign rnd_y = py4_q + PROD_W'(1 << (FRAC_W-1));

  assign res_d.mid_angle       = ang4_q;
  assign res_d.mid_range       = mr4_q;
  assign res_d.pos_x           = rnd_x[FRAC_W+POS_W-1:FRAC_W] + rssf_pkg::QUAD_X_OFF[q4_q];
  assign res_d.pos_y           = rnd_y[FRAC_W+POS_W-1:FRAC_W] + rssf_pkg::QUAD_Y_OFF[q4_q];
  assign res_d.source_quadrant = q4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ang1_q <= ang_wrap;
    mr1_q  <= seg_i.mid_range;
    q1_q   <= seg_i.quadrant;

    ang2_q <= ang1_q;
    mr2_q  <= mr1_q;
    q2_q   <= q1_q;
    aq2_q  <= aq;
    f2_q   <= ang_rem[F_W-1:0];

    ang3_q <= ang2_q;
    mr3_q  <= mr2_q;
    q3_q   <= q2_q;
    sn3_q  <= sn;
    cs3_q  <= cs;

    ang4_q <= ang3_q;
    mr4_q  <= mr3_q;
    q4_q   <= q3_q;
    px4_q  <= PROD_W'($signed({1'b0, mr3_q})) * PROD_W'(cs3_q);
    py4_q  <= PROD_W'($signed({1'b0, mr3_q})) * PROD_W'(sn3_q);
  end

  rssf_fifo #(
    .WIDTH ($bits(rssf_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (vld_q[STAGES-1]),
    .wdata_i (res_d),
    .pop_i   (pop_i),
    .rdata_o (res_o),
    .full_o  (out_full),
    .empty_o (empty_o),
    .count_o (out_count)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[STAGES-1] |-> !out_full)
    else $error("result dropped: output queue full");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= USED_W'(OUT_DEPTH))
    else $error("items in flight exceed output queue space");

endmodule

// ===== tb/range_scan_segment_finder_tb.sv =====
module range_scan_segment_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rssf_pkg::*;

  localparam int unsigned SCAN_N       = SCAN_ANGLES_DEF;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 300;

  class seg_scoreboard;
    res_t        pending_segs[$];
    int unsigned thr;
    int unsigned min_len;
    int unsigned min_rng;
    int unsigned next_idx;
    int unsigned run_idx;
    int unsigned run_rng;
    int unsigned prev_rng;
    int          sin_tab [0:90];
    int unsigned n_errors;

    function new();
      longint x;
      longint y;
      longint nx;
      longint v;
      int     d;
      x = longint'(1) <<< 30;
      y = 0;
      for (d = 0; d <= 90; d++) begin
        if (d != 0) begin
          // rotate by one degree in Q2.30, round half up
          nx = (x * COS1_Q30 - y * SIN1_Q30 + (longint'(1) <<< 29)) >>> 30;
          y  = (y * COS1_Q30 + x * SIN1_Q30 + (longint'(1) <<< 29)) >>> 30;
          x  = nx;
        end
        v = (y + 64'sd16384) >>> 15;
        sin_tab[d] = (v > 32767) ? 32767 : (v < 0) ? 0 : int'(v);
      end
      thr      = 32'(DELTA_THRESHOLD_RST);
      min_len  = 32'(MIN_LENGTH_RST);
      min_rng  = 32'(MIN_RANGE_RST);
      next_idx = 0;
      run_idx  = 0;
      run_rng  = 0;
      prev_rng = 0;
      n_errors = 0;
    endfunction

    function void report(string msg);
      n_errors++;
      if (n_errors <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function string seg_str(res_t s);
      return $sformatf("angle=%0d range=%0d x=%0d y=%0d quadrant=%0d",
                       s.mid_angle, s.mid_range, s.pos_x, s.pos_y, s.source_quadrant);
    endfunction

    function void set_reg(reg_e a, int unsigned v);
      case (a)
        REG_DELTA_THRESHOLD: thr     = v & ((1 << THR_W) - 1);
        REG_MIN_LENGTH:      min_len = v & ((1 << LEN_W) - 1);
        REG_MIN_RANGE:       min_rng = v & ((1 << RANGE_W) - 1);
        default: ;
      endcase
    endfunction

    function int mul_round(int unsigned r, int t);
      longint p;
      p = longint'(r) * longint'(t) + 64'sd16384;
      return int'(p >>> 15);
    endfunction

    function void close_segment(int unsigned s, int unsigned e, int unsigned rs,
                                int unsigned re, int unsigned q);
      res_t        seg;
      int unsigned ang;
      int unsigned mr;
      int unsigned f;
      int          sn;
      int          cs;
      int          px;
      int          py;
      if (int'(e) - int'(s) <= int'(min_len)) return;
      mr = (rs + re) >> 1;
      if (mr <= min_rng) return;
      ang = (s + e) / 2 + 90 * q;
      if (ang >= 360) ang -= 360;
      f = ang % 90;
      case (ang / 90)
        0: begin
          sn = sin_tab[f];
          cs = sin_tab[90 - f];
        end
        1: begin
          sn = sin_tab[90 - f];
          cs = -sin_tab[f];
        end
        2: begin
          sn = -sin_tab[f];
          cs = -sin_tab[90 - f];
        end
        default: begin
          sn = -sin_tab[90 - f];
          cs = sin_tab[f];
        end
      endcase
      px = mul_round(mr, cs) + ((q == 1 || q == 2) ? 90 : 0);
      py = mul_round(mr, sn) + ((q == 2 || q == 3) ? 90 : 0);
      seg.mid_angle       = ang[ANG_W-1:0];
      seg.mid_range       = mr[RANGE_W-1:0];
      seg.pos_x           = px[POS_W-1:0];
      seg.pos_y           = py[POS_W-1:0];
      seg.source_quadrant = q[QUAD_W-1:0];
      pending_segs.push_back(seg);
    endfunction

    function void note_sample(int unsigned r, int unsigned q, bit last);
      int unsigned k;
      int unsigned diff;
      k = (next_idx >= SCAN_N) ? SCAN_N - 1 : next_idx;
      if (k == 0) begin
        run_idx = 0;
        run_rng = r;
      end else begin
        diff = (r > prev_rng) ? r - prev_rng : prev_rng - r;
        if (diff < thr) begin
          if (last) close_segment(run_idx, k, run_rng, r, q);
        end else begin
          close_segment(run_idx, k - 1, run_rng, prev_rng, q);
          run_idx = k;
          run_rng = r;
        end
      end
      prev_rng = r;
      if (last) next_idx = 0;
      else if (k < SCAN_N - 1) next_idx = k + 1;
      else next_idx = k;
    endfunction

    function void check_segment(res_t got);
      res_t want;
      if (pending_segs.size() == 0) begin
        report({"unexpected segment: ", seg_str(got)});
        return;
      end
      want = pending_segs.pop_front();
      if (got.mid_angle !== want.mid_angle || got.mid_range !== want.mid_range ||
          got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.source_quadrant !== want.source_quadrant)
        report({"segment mismatch: expected ", seg_str(want), " got ", seg_str(got)});
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [RANGE_W-1:0]    range_sample_i = '0;
  logic [QUAD_W-1:0]     quadrant_i = '0;
  logic                  last_sample_i = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [ANG_W-1:0]      mid_angle_o;
  logic [RANGE_W-1:0]    mid_range_o;
  logic signed [POS_W-1:0] pos_x_o;
  logic signed [POS_W-1:0] pos_y_o;
  logic [QUAD_W-1:0]     source_quadrant_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  seg_scoreboard sb = new();

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned cur_thr = 32'(DELTA_THRESHOLD_RST);
  int unsigned items_sent = 0;
  bit          hold_req = 1'b0;

  range_scan_segment_finder u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .range_sample_i    (range_sample_i),
    .quadrant_i        (quadrant_i),
    .last_sample_i     (last_sample_i),
    .empty             (empty),
    .pop               (pop),
    .mid_angle_o       (mid_angle_o),
    .mid_range_o       (mid_range_o),
    .pos_x_o           (pos_x_o),
    .pos_y_o           (pos_y_o),
    .source_quadrant_o (source_quadrant_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_sample(input logic [RANGE_W-1:0] r, input logic [QUAD_W-1:0] q,
                             input logic last);
    int unsigned gap;
    gap = 0;
    if (snd_idle_pct != 0 && $urandom_range(99, 0) < snd_idle_pct)
      gap = $urandom_range(9, 1);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    range_sample_i <= r;
    quadrant_i     <= q;
    last_sample_i  <= last;
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_sample(32'(r), 32'(q), last);
    items_sent++;
  endtask

  // q_sel above 3 picks a random quadrant; split forces a break at that index
  task automatic send_scan(input int unsigned len, input int unsigned step,
                           input int unsigned jump_pct, input int unsigned split,
                           input int unsigned q_sel, input bit mark_end);
    logic [RANGE_W-1:0] rng;
    logic [QUAD_W-1:0]  quad;
    bit                 noisy_quad;
    int                 v;
    int unsigned        i;
    rng        = RANGE_W'($urandom_range(1023, 0));
    quad       = QUAD_W'((q_sel > 3) ? $urandom_range(3, 0) : q_sel);
    noisy_quad = (q_sel > 3) && ($urandom_range(99, 0) < 5);
    for (i = 0; i < len; i++) begin
      if (i != 0 && split != 0 && i == split) begin
        rng = rng ^ 10'h200;
      end else if (i != 0) begin
        if ($urandom_range(99, 0) < jump_pct) begin
          rng = RANGE_W'($urandom_range(1023, 0));
        end else begin
          v = int'(rng) + int'($urandom_range(2 * step, 0)) - int'(step);
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
          rng = v[RANGE_W-1:0];
        end
      end
      if (noisy_quad) quad = QUAD_W'($urandom_range(3, 0));
      send_sample(rng, quad, mark_end && (i == len - 1));
    end
  endtask

  task automatic random_scans(input int unsigned n_items, input int unsigned jump_max);
    int unsigned stop_at;
    int unsigned step;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      step = (cur_thr > 1) ? cur_thr - 1 : 0;
      if (step > 200) step = 200;
      if ($urandom_range(9, 0) == 0) step = (cur_thr > 150) ? 300 : 2 * cur_thr + 1;
      case ($urandom_range(11, 0))
        0:    send_scan($urandom_range(170, 100), step, 0, $urandom_range(90, 30), 4, 1'b1);
        1, 2: send_scan($urandom_range(4, 1), step, jump_max, 0, 4,
                        $urandom_range(9, 0) != 0);
        default: send_scan($urandom_range(50, 6), step, $urandom_range(jump_max, 0), 0, 4,
                           $urandom_range(9, 0) != 0);
      endcase
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_segs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input reg_e a, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({a, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_e a, input int unsigned v);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b1, a, APB_DATA_W'(v), rd);
    sb.set_reg(a, v);
    apb_access(1'b0, a, '0, rd);
    if (rd !== APB_DATA_W'(v))
      sb.report($sformatf("register %s reads %0d after writing %0d", a.name(), rd, v));
  endtask

  task automatic configure(input int unsigned thr, input int unsigned mlen,
                           input int unsigned mrng);
    drain();
    cfg_write(REG_DELTA_THRESHOLD, thr);
    cfg_write(REG_MIN_LENGTH, mlen);
    cfg_write(REG_MIN_RANGE, mrng);
    cur_thr = thr;
    snd_idle_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 10);
    rcv_idle_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 10);
  endtask

  initial begin : result_sink
    res_t        got;
    int unsigned stall;
    bit          seen;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = 0;
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (rcv_idle_pct != 0 && $urandom_range(99, 0) < rcv_idle_pct) begin
        stall = $urandom_range(9, 1);
      end
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(negedge clk_i);
      seen                = !empty;
      got.mid_angle       = mid_angle_o;
      got.mid_range       = mid_range_o;
      got.pos_x           = pos_x_o;
      got.pos_y           = pos_y_o;
      got.source_quadrant = source_quadrant_o;
      @(posedge clk_i);
      if (seen) sb.check_segment(got);
    end
  end

  initial begin : stimulus
    int unsigned dir_rng [24];
    int unsigned i;
    int unsigned ph;
    dir_rng = '{1023, 1022, 1020, 1023, 1021, 1019, 1018, 0, 1, 2, 3, 4, 2, 3,
                600, 601, 602, 603, 604, 605, 606, 607, 100, 300};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: break, run ending on the last mark, break on the last
    // sample, a lone single-sample scan
    for (i = 0; i < 24; i++)
      send_sample(RANGE_W'(dir_rng[i]), QUAD_W'((i < 14) ? 0 : (i < 23) ? 3 : 2),
                  i == 13 || i == 22 || i == 23);
    // index saturates past the scan length; late run in quadrant 3 wraps past 360
    send_scan(130, 3, 0, 60, 3, 1'b1);
    snd_idle_pct = 20;
    rcv_idle_pct = 20;
    random_scans(80, 8);

    configure(0, 0, 0);
    random_scans(30, 8);
    configure(1023, 511, 1023);
    random_scans(30, 8);
    configure(1023, 0, 0);
    random_scans(60, 8);

    // stall the result side long enough to back up into full; every short
    // scan closes one run
    configure(16, 1, 0);
    snd_idle_pct = 0;
    hold_req = 1'b1;
    for (i = 0; i < 30; i++)
      send_scan(4, 4, 0, 0, 4, 1'b1);

    for (ph = 0; ph < 3; ph++) begin
      configure($urandom_range(64, 1), $urandom_range(20, 0), $urandom_range(700, 0));
      random_scans(30, 10);
      drain();
      random_scans(30, 10);
    end

    configure(10, 2, 200);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_scans(100, 10);
    drain();

    if (sb.n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
